@@ rtl/lpfh_pkg.sv @@
// package for the length-prefixed frame header parser
// frame kind codes, type byte codes, header offsets and the result record
// no dependencies
package lpfh_pkg;

  typedef enum logic [2:0] {
    KIND_DIRECT  = 3'd0,
    KIND_REMOTE  = 3'd1,
    KIND_TARGET  = 3'd2,
    KIND_BCAST   = 3'd3,
    KIND_UNKNOWN = 3'd4,
    KIND_SHORT   = 3'd5
  } frame_kind_e;

  localparam int unsigned PosW = 17;

  localparam logic [7:0] TYPE_DIRECT = 8'h00;
  localparam logic [7:0] TYPE_REMOTE = 8'h01;
  localparam logic [7:0] TYPE_TARGET = 8'h80;
  localparam logic [7:0] TYPE_BCAST  = 8'h81;

  localparam logic [7:0] ADDR_KIND_IPV4 = 8'd1;
  localparam logic [7:0] ADDR_KIND_IPV6 = 8'd2;

  // frame offsets, counted from the first length byte
  localparam logic [PosW-1:0] POS_LEN_HI     = 17'd0;
  localparam logic [PosW-1:0] POS_LEN_LO     = 17'd1;
  localparam logic [PosW-1:0] POS_TYPE       = 17'd2;
  localparam logic [PosW-1:0] POS_STAMP_FIRST = 17'd4;
  localparam logic [PosW-1:0] POS_STAMP_LAST = 17'd11;
  localparam logic [PosW-1:0] POS_MAC_FIRST  = 17'd12;
  localparam logic [PosW-1:0] POS_MAC_LAST   = 17'd17;
  localparam logic [PosW-1:0] POS_PORT_FIRST = 17'd18;
  localparam logic [PosW-1:0] POS_PORT_LAST  = 17'd19;
  localparam logic [PosW-1:0] POS_ADDR_KIND  = 17'd20;
  localparam logic [PosW-1:0] POS_IPV4_FIRST = 17'd21;
  localparam logic [PosW-1:0] POS_IPV4_LAST  = 17'd24;

  // minimum body lengths per kind
  localparam logic [15:0] LEN_MIN_DIRECT = 16'd18;
  localparam logic [15:0] LEN_MIN_REMOTE = 16'd19;
  localparam logic [15:0] LEN_MIN_IPV4   = 16'd23;
  localparam logic [15:0] LEN_MIN_IPV6   = 16'd35;

  typedef struct packed {
    logic [31:0] ipv4_address;
    logic [7:0]  address_kind;
    logic [15:0] node_port;
    logic [47:0] node_mac;
    logic [63:0] announce_stamp;
    logic [15:0] body_length;
    logic [7:0]  frame_byte;
  } out_data_t;

  typedef struct packed {
    out_data_t   data;
    frame_kind_e kind;
    logic        last;
  } result_t;

endpackage

@@ rtl/length_prefixed_frame_header_parser.sv @@
// length-prefixed frame header parser, top level
// deframes a byte stream with 16-bit big-endian length prefixes
// depends on lpfh_pkg
//
// usage:
//   s_axis carries one link byte per transaction in tdata[7:0].
//   m_axis returns one transaction per input byte: the byte itself, tlast on
//   the final byte of each frame (length prefix counted), the frame kind on
//   tuser, and the header fields captured at fixed offsets in tdata.
//   kind and header fields other than body_length are zero except on the final byte of a frame.
// throughput:
//   one byte per cycle while m_axis_tready_i is high; results are registered.
//   the parse state and the result for a byte are formed in the same cycle
//   from the frame position counter.
// reset:
//   rst_ni clears the position counter and captures, so the next byte is
//   taken as the first length byte; both output stages are emptied.
// stall:
//   an output register plus one skid entry hold results while m_axis_tready_i
//   is low; s_axis_tready_o drops only once the skid entry is full.
module length_prefixed_frame_header_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [7:0] frame_byte, [23:8] body_length, [87:24] announce_stamp,
  // [135:88] node_mac, [151:136] node_port, [159:152] address_kind,
  // [191:160] ipv4_address
  output logic [191:0] m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  output logic [2:0]   m_axis_tuser_o    // [2:0] frame_kind
);

  logic [lpfh_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [63:0] stamp_q, stamp_d;
  logic [47:0] mac_q, mac_d;
  logic [15:0] port_q, port_d;
  logic [7:0]  kind_q, kind_d;
  logic [31:0] ipv4_q, ipv4_d;

  logic        in_fire, out_fire, last;
  logic [7:0]  b;
  lpfh_pkg::frame_kind_e fkind;
  lpfh_pkg::result_t     res;

  logic                out_valid_q, out_valid_d;
  logic                skid_valid_q, skid_valid_d;
  lpfh_pkg::result_t   out_q, out_d;
  lpfh_pkg::result_t   skid_q, skid_d;

  assign b        = s_axis_tdata_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = out_valid_q && m_axis_tready_i;

  // header capture
  always_comb begin
    len_d   = len_q;
    type_d  = type_q;
    stamp_d = stamp_q;
    mac_d   = mac_q;
    port_d  = port_q;
    kind_d  = kind_q;
    ipv4_d  = ipv4_q;
    if (pos_q == lpfh_pkg::POS_LEN_HI) begin
      len_d   = {b, 8'h00};
      type_d  = '0;
      stamp_d = '0;
      mac_d   = '0;
      port_d  = '0;
      kind_d  = '0;
      ipv4_d  = '0;
    end else if (pos_q == lpfh_pkg::POS_LEN_LO) begin
      len_d = {len_q[15:8], b};
    end else if (pos_q == lpfh_pkg::POS_TYPE) begin
      type_d = b;
    end else if (pos_q >= lpfh_pkg::POS_STAMP_FIRST && pos_q <= lpfh_pkg::POS_STAMP_LAST) begin
      stamp_d = {stamp_q[55:0], b};
    end else if (pos_q >= lpfh_pkg::POS_MAC_FIRST && pos_q <= lpfh_pkg::POS_MAC_LAST) begin
      mac_d = {mac_q[39:0], b};
    end else if (pos_q >= lpfh_pkg::POS_PORT_FIRST && pos_q <= lpfh_pkg::POS_PORT_LAST) begin
      port_d = {port_q[7:0], b};
    end else if (pos_q == lpfh_pkg::POS_ADDR_KIND) begin
      kind_d = b;
    end else if (pos_q >= lpfh_pkg::POS_IPV4_FIRST && pos_q <= lpfh_pkg::POS_IPV4_LAST) begin
      ipv4_d = {ipv4_q[23:0], b};
    end
  end

  assign last  = (pos_q != lpfh_pkg::POS_LEN_HI) &&
                 (pos_q == ({1'b0, len_d} + 17'd1));
  assign pos_d = last ? '0 : pos_q + 17'd1;

  // frame classification
  always_comb begin
    case (type_d)
      lpfh_pkg::TYPE_DIRECT: begin
        fkind = (len_d >= lpfh_pkg::LEN_MIN_DIRECT) ? lpfh_pkg::KIND_DIRECT
                                                    : lpfh_pkg::KIND_SHORT;
      end
      lpfh_pkg::TYPE_REMOTE: begin
        if (len_d < lpfh_pkg::LEN_MIN_REMOTE) begin
          fkind = lpfh_pkg::KIND_SHORT;
        end else if (kind_d == lpfh_pkg::ADDR_KIND_IPV4 && len_d < lpfh_pkg::LEN_MIN_IPV4) begin
          fkind = lpfh_pkg::KIND_SHORT;
        end else if (kind_d == lpfh_pkg::ADDR_KIND_IPV6 && len_d < lpfh_pkg::LEN_MIN_IPV6) begin
          fkind = lpfh_pkg::KIND_SHORT;
        end else begin
          fkind = lpfh_pkg::KIND_REMOTE;
        end
      end
      lpfh_pkg::TYPE_TARGET: fkind = lpfh_pkg::KIND_TARGET;
      lpfh_pkg::TYPE_BCAST:  fkind = lpfh_pkg::KIND_BCAST;
      default:               fkind = lpfh_pkg::KIND_UNKNOWN;
    endcase
    if (len_d == 16'd0) begin
      fkind = lpfh_pkg::KIND_SHORT;
    end
  end

  // result record
  always_comb begin
    res                 = '0;
    res.data.frame_byte = b;
    res.last            = last;
    res.data.body_length = (pos_q == lpfh_pkg::POS_LEN_HI) ? 16'd0 : len_d;
    if (last) begin
      res.kind = fkind;
      if (fkind == lpfh_pkg::KIND_DIRECT || fkind == lpfh_pkg::KIND_REMOTE) begin
        res.data.announce_stamp = stamp_d;
        res.data.node_mac       = mac_d;
        res.data.node_port      = port_d;
      end
      if (fkind == lpfh_pkg::KIND_REMOTE) begin
        res.data.address_kind = kind_d;
        if (kind_d == lpfh_pkg::ADDR_KIND_IPV4) begin
          res.data.ipv4_address = ipv4_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
      stamp_q <= '0;
      mac_q   <= '0;
      port_q  <= '0;
      kind_q  <= '0;
      ipv4_q  <= '0;
    end else if (in_fire) begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      type_q  <= type_d;
      stamp_q <= stamp_d;
      mac_q   <= mac_d;
      port_q  <= port_d;
      kind_q  <= kind_d;
      ipv4_q  <= ipv4_d;
    end
  end

  // output register with skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_fire || !out_valid_q) begin
      out_valid_d  = skid_valid_q || in_fire;
      out_d        = skid_valid_q ? skid_q : res;
      skid_valid_d = 1'b0;
    end else if (in_fire) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.data;
  assign m_axis_tlast_o  = out_q.last;
  assign m_axis_tuser_o  = out_q.kind;

endmodule

@@ rtl/lpfh_checker.sv @@
// port-level checks for the length-prefixed frame header parser
// bound to length_prefixed_frame_header_parser; depends on lpfh_pkg
module lpfh_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [191:0] m_axis_tdata_o,
  input logic         m_axis_tlast_o,
  input logic [2:0]   m_axis_tuser_o
);

  // stalled transaction keeps valid
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("m_axis_tvalid dropped while stalled");

  // stalled transaction keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("m_axis payload changed while stalled");

  // kind and header fields other than body_length only on the last byte of a frame
  a_mid_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |->
      m_axis_tuser_o == '0 && m_axis_tdata_o[191:24] == '0)
    else $error("header fields reported before end of frame");

  // kind code in range
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o <= lpfh_pkg::KIND_SHORT)
    else $error("frame kind out of range");

  // input back-pressure only with a full output stage
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with an empty output stage");

endmodule

bind length_prefixed_frame_header_parser lpfh_checker u_lpfh_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

@@ tb/tb.sv @@
// testbench for length_prefixed_frame_header_parser: random framed byte
// streams with bursty input and a stalling output, checked per transaction
// depends on lpfh_pkg and the parser top level
`timescale 1ns / 1ps

module tb;

  logic         clk_i    = 1'b0;
  logic         rst_ni   = 1'b0;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata  = 8'h00;
  logic         m_tready = 1'b0;
  logic         s_axis_tready_o;
  logic         m_axis_tvalid_o;
  logic [191:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic [2:0]   m_axis_tuser_o;

  int unsigned  items_sent  = 0;
  int unsigned  burst_left  = 0;
  bit           hold_active = 1'b0;

  class frame_scoreboard;
    logic [lpfh_pkg::PosW-1:0] pos;
    logic [15:0]               len_reg;
    logic [7:0]                type_reg;
    logic [63:0]               stamp_reg;
    logic [47:0]               mac_reg;
    logic [15:0]               port_reg;
    logic [7:0]                akind_reg;
    logic [31:0]               ipv4_reg;
    lpfh_pkg::result_t         pending_results[$];
    int unsigned               mismatch_count;
    int unsigned               checked;

    function new();
      pos = '0;
      len_reg = '0;
      type_reg = '0;
      stamp_reg = '0;
      mac_reg = '0;
      port_reg = '0;
      akind_reg = '0;
      ipv4_reg = '0;
      mismatch_count = 0;
      checked = 0;
    endfunction

    function lpfh_pkg::frame_kind_e classify();
      if (len_reg == 16'd0) return lpfh_pkg::KIND_SHORT;
      if (type_reg == lpfh_pkg::TYPE_DIRECT) begin
        if (len_reg >= lpfh_pkg::LEN_MIN_DIRECT) return lpfh_pkg::KIND_DIRECT;
        return lpfh_pkg::KIND_SHORT;
      end
      if (type_reg == lpfh_pkg::TYPE_REMOTE) begin
        if (len_reg < lpfh_pkg::LEN_MIN_REMOTE) return lpfh_pkg::KIND_SHORT;
        if (akind_reg == lpfh_pkg::ADDR_KIND_IPV4 && len_reg < lpfh_pkg::LEN_MIN_IPV4)
          return lpfh_pkg::KIND_SHORT;
        if (akind_reg == lpfh_pkg::ADDR_KIND_IPV6 && len_reg < lpfh_pkg::LEN_MIN_IPV6)
          return lpfh_pkg::KIND_SHORT;
        return lpfh_pkg::KIND_REMOTE;
      end
      if (type_reg == lpfh_pkg::TYPE_TARGET) return lpfh_pkg::KIND_TARGET;
      if (type_reg == lpfh_pkg::TYPE_BCAST) return lpfh_pkg::KIND_BCAST;
      return lpfh_pkg::KIND_UNKNOWN;
    endfunction

    // one transaction in, one result predicted
    function void predict_byte(logic [7:0] b);
      logic [lpfh_pkg::PosW-1:0] p;
      lpfh_pkg::result_t         res;
      lpfh_pkg::frame_kind_e     k;
      p = pos;
      res = '0;
      if (p == lpfh_pkg::POS_LEN_HI) begin
        len_reg = {b, 8'h00};
        type_reg = '0;
        stamp_reg = '0;
        mac_reg = '0;
        port_reg = '0;
        akind_reg = '0;
        ipv4_reg = '0;
      end else if (p == lpfh_pkg::POS_LEN_LO) begin
        len_reg[7:0] = b;
      end else if (p == lpfh_pkg::POS_TYPE) begin
        type_reg = b;
      end else if (p >= lpfh_pkg::POS_STAMP_FIRST && p <= lpfh_pkg::POS_STAMP_LAST) begin
        stamp_reg = {stamp_reg[55:0], b};
      end else if (p >= lpfh_pkg::POS_MAC_FIRST && p <= lpfh_pkg::POS_MAC_LAST) begin
        mac_reg = {mac_reg[39:0], b};
      end else if (p >= lpfh_pkg::POS_PORT_FIRST && p <= lpfh_pkg::POS_PORT_LAST) begin
        port_reg = {port_reg[7:0], b};
      end else if (p == lpfh_pkg::POS_ADDR_KIND) begin
        akind_reg = b;
      end else if (p >= lpfh_pkg::POS_IPV4_FIRST && p <= lpfh_pkg::POS_IPV4_LAST) begin
        ipv4_reg = {ipv4_reg[23:0], b};
      end
      res.data.frame_byte = b;
      res.data.body_length = (p == lpfh_pkg::POS_LEN_HI) ? 16'd0 : len_reg;
      res.last = (p != lpfh_pkg::POS_LEN_HI) && (p == {1'b0, len_reg} + 17'd1);
      if (res.last) begin
        k = classify();
        res.kind = k;
        if (k == lpfh_pkg::KIND_DIRECT || k == lpfh_pkg::KIND_REMOTE) begin
          res.data.announce_stamp = stamp_reg;
          res.data.node_mac = mac_reg;
          res.data.node_port = port_reg;
        end
        if (k == lpfh_pkg::KIND_REMOTE) begin
          res.data.address_kind = akind_reg;
          if (akind_reg == lpfh_pkg::ADDR_KIND_IPV4) res.data.ipv4_address = ipv4_reg;
        end
        pos = '0;
      end else begin
        pos = p + 17'd1;
      end
      pending_results.push_back(res);
    endfunction

    task report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch: result %0d %s got %0h want %0h", checked, what, got, want);
      mismatch_count++;
    endtask

    task check_result(input lpfh_pkg::out_data_t got, input logic last,
                      input logic [2:0] kind);
      lpfh_pkg::result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected transaction", 64'(got.frame_byte), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (got.frame_byte !== want.data.frame_byte)
          report("frame_byte", 64'(got.frame_byte), 64'(want.data.frame_byte));
        if (last !== want.last) report("frame_end", 64'(last), 64'(want.last));
        if (kind !== want.kind) report("frame_kind", 64'(kind), 64'(want.kind));
        if (got.body_length !== want.data.body_length)
          report("body_length", 64'(got.body_length), 64'(want.data.body_length));
        if (got.announce_stamp !== want.data.announce_stamp)
          report("announce_stamp", got.announce_stamp, want.data.announce_stamp);
        if (got.node_mac !== want.data.node_mac)
          report("node_mac", 64'(got.node_mac), 64'(want.data.node_mac));
        if (got.node_port !== want.data.node_port)
          report("node_port", 64'(got.node_port), 64'(want.data.node_port));
        if (got.address_kind !== want.data.address_kind)
          report("address_kind", 64'(got.address_kind), 64'(want.data.address_kind));
        if (got.ipv4_address !== want.data.ipv4_address)
          report("ipv4_address", 64'(got.ipv4_address), 64'(want.data.ipv4_address));
      end
      checked++;
    endtask
  endclass

  frame_scoreboard sb;

  length_prefixed_frame_header_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) sb.predict_byte(s_tdata);
      if (m_axis_tvalid_o && m_tready)
        sb.check_result(lpfh_pkg::out_data_t'(m_axis_tdata_o), m_axis_tlast_o,
                        m_axis_tuser_o);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else if (!hold_active) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
  endtask

  task automatic send_frame(input int len, input logic [7:0] type_val,
                            input logic [7:0] addr_kind);
    logic [15:0] len16;
    len16 = len[15:0];
    for (int i = 0; i < len + 2; i++) begin
      if (i == 0) send_byte(len16[15:8]);
      else if (i == 1) send_byte(len16[7:0]);
      else if (i == 2) send_byte(type_val);
      else if (i == int'(lpfh_pkg::POS_ADDR_KIND)) send_byte(addr_kind);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  function automatic logic [7:0] pick_addr_kind();
    case ($urandom_range(0, 3))
      0: return lpfh_pkg::ADDR_KIND_IPV4;
      1: return lpfh_pkg::ADDR_KIND_IPV6;
      2: return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // lengths around the remote announce minimums
  function automatic int pick_remote_len();
    case ($urandom_range(0, 9))
      0: return 17;
      1: return 18;
      2: return 19;
      3: return 20;
      4: return 22;
      5: return 23;
      6: return 24;
      7: return 34;
      8: return 35;
      default: return 36;
    endcase
  endfunction

  // receiver: stall patterns plus one long hold-off to back up the input
  initial begin : sink
    int unsigned period;
    int unsigned duty;
    int unsigned span;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && sb.checked >= 500) begin
        held = 1'b1;
        @(posedge clk_i);
        m_tready <= 1'b0;
        hold_active = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_active = 1'b0;
      end
      period = $urandom_range(1, 8);
      duty = $urandom_range(0, period - 1);
      span = $urandom_range(20, 200);
      if ($urandom_range(0, 3) == 0) duty = 0;
      for (int unsigned ph = 0; ph < span; ph++) begin
        @(posedge clk_i);
        m_tready <= ((ph % period) >= duty);
      end
    end
  end

  initial begin : stimulus
    int          len;
    logic [7:0]  tb_type;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty body, one-byte bodies of each type, unknown type
    send_frame(0, lpfh_pkg::TYPE_DIRECT, 8'h00);
    send_frame(1, lpfh_pkg::TYPE_TARGET, 8'h00);
    send_frame(1, lpfh_pkg::TYPE_BCAST, 8'h00);
    send_frame(1, 8'hFF, 8'h00);
    send_frame(1, lpfh_pkg::TYPE_DIRECT, 8'h00);
    send_frame(1, lpfh_pkg::TYPE_REMOTE, 8'h00);
    send_frame(2, 8'h7F, 8'h00);

    while (items_sent < 1400) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          len = ($urandom_range(0, 1) == 0) ? int'($urandom_range(16, 19))
                                            : int'($urandom_range(0, 40));
          send_frame(len, lpfh_pkg::TYPE_DIRECT, pick_addr_kind());
        end
        2, 3, 4: begin
          len = ($urandom_range(0, 1) == 0) ? pick_remote_len()
                                            : int'($urandom_range(19, 45));
          send_frame(len, lpfh_pkg::TYPE_REMOTE, pick_addr_kind());
        end
        5: send_frame(int'($urandom_range(0, 30)), lpfh_pkg::TYPE_TARGET, pick_addr_kind());
        6: send_frame(int'($urandom_range(0, 30)), lpfh_pkg::TYPE_BCAST, pick_addr_kind());
        7, 8: begin
          tb_type = 8'($urandom_range(0, 255));
          send_frame(int'($urandom_range(0, 60)), tb_type, pick_addr_kind());
        end
        default: begin
          tb_type = 8'($urandom_range(0, 255));
          send_frame(int'($urandom_range(100, 400)), tb_type, pick_addr_kind());
        end
      endcase
    end

    s_tvalid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
rtl/lpfh_pkg.sv
rtl/length_prefixed_frame_header_parser.sv
rtl/lpfh_checker.sv
tb/tb.sv
